### design/kmmt_pkg.sv
// Package for the keyed message mailbox table.
// Holds action and status codes, sizing constants and the front-to-back command struct.
package kmmt_pkg;

  localparam int SLOTS_DEF       = 8;
  localparam int MAX_PAYLOAD_DEF = 16;
  localparam logic [7:0] FREE_NODE = 8'd255;

  localparam logic [1:0] ACT_SET   = 2'd0;
  localparam logic [1:0] ACT_LOOK  = 2'd1;
  localparam logic [1:0] ACT_CLR   = 2'd2;
  localparam logic [1:0] ACT_CLRA  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_LONG  = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  // Command handed from the front to the back. Set bytes already sit in staging.
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] group_id;
    logic [7:0] node_id;
    logic [1:0] pre_status;  // empty or too long, decided at the front
    logic [6:0] count;       // staged byte count of a committing set
  } kmmt_cmd_t;

endpackage

### design/kmmt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module kmmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### design/kmmt_front.sv
// Front part: accepts items, stages set bytes, and queues commands for the back.
// Depends on kmmt_pkg and kmmt_ram.
module kmmt_front #(
  parameter int MAX_PAYLOAD = kmmt_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [1:0]                       action,
  input  logic [7:0]                       group_id,
  input  logic [7:0]                       node_id,
  input  logic [7:0]                       data_byte,
  input  logic                             has_data,
  input  logic                             byte_last,
  input  logic                             back_busy,
  output logic                             busy,
  output logic                             cmd_valid,
  output kmmt_pkg::kmmt_cmd_t              cmd,
  input  logic                             cmd_take,
  input  logic [$clog2(MAX_PAYLOAD)-1:0]   stage_raddr,
  output logic [7:0]                       stage_rdata
);
  import kmmt_pkg::*;

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [6:0] count;
  logic       overflow;
  kmmt_cmd_t  cmd_next;
  logic       accept;
  logic       wr;
  logic [6:0] cnt_after;

  assign accept = start && !busy;
  // One-entry queue; every item must also wait for the back so the
  // staging buffer is not overwritten while being copied.
  assign busy = cmd_valid || back_busy;

  assign wr = accept && action == ACT_SET && has_data && count < 7'(MAX_PAYLOAD);
  assign cnt_after = wr ? count + 7'd1 : count;

  kmmt_ram #(.WIDTH(8), .DEPTH(MAX_PAYLOAD)) u_stage (
    .clk(clk), .we(wr), .waddr(count[AW-1:0]), .wdata(data_byte),
    .raddr(stage_raddr), .rdata(stage_rdata)
  );

  // Classify the accepted item.
  always_comb begin
    cmd_next.action   = action;
    cmd_next.group_id = group_id;
    cmd_next.node_id  = node_id;
    cmd_next.count    = cnt_after;
    if (cnt_after == 7'd0) begin
      cmd_next.pre_status = ST_EMPTY;
    end else if (overflow || (has_data && !wr)) begin
      cmd_next.pre_status = ST_LONG;
    end else begin
      cmd_next.pre_status = ST_OK;
    end
  end

  // Staging counters and the queue register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= 7'd0;
      overflow  <= 1'b0;
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_take) begin
        cmd_valid <= 1'b0;
      end
      if (accept) begin
        if (action == ACT_SET) begin
          if (byte_last) begin
            count     <= 7'd0;
            overflow  <= 1'b0;
            cmd_valid <= 1'b1;
          end else begin
            count <= cnt_after;
            if (has_data && !wr) begin
              overflow <= 1'b1;
            end
          end
        end else begin
          cmd_valid <= 1'b1;
        end
      end
    end
    if (accept) begin
      cmd <= cmd_next;
    end
  end
endmodule

### design/kmmt_back.sv
// Back part: searches the slot table, copies staged payloads, reads out lookups.
// Depends on kmmt_pkg and kmmt_ram.
module kmmt_back #(
  parameter int SLOTS       = kmmt_pkg::SLOTS_DEF,
  parameter int MAX_PAYLOAD = kmmt_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  input  kmmt_pkg::kmmt_cmd_t            cmd,
  output logic                           cmd_take,
  output logic                           back_busy,
  output logic [$clog2(MAX_PAYLOAD)-1:0] stage_raddr,
  input  logic [7:0]                     stage_rdata,
  output logic                           strobe,
  output logic [1:0]                     status,
  output logic                           found,
  output logic [5:0]                     entry_length,
  output logic [7:0]                     payload_byte,
  output logic                           result_last
);
  import kmmt_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int DEPTH = SLOTS * MAX_PAYLOAD;
  localparam int MW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRCH = 3'd1;
  localparam logic [2:0] S_COPY = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;

  logic [2:0]  state;
  kmmt_cmd_t   cur;
  logic [7:0]  slot_group [SLOTS];
  logic [7:0]  slot_node [SLOTS];
  logic [5:0]  slot_length [SLOTS];
  logic [SW:0] scan;
  logic        key_hit, free_hit;
  logic [SW-1:0] key_idx, free_idx;
  logic [SW-1:0] sel;
  logic [6:0]  pos;
  logic [6:0]  len;
  logic        mem_we;
  logic [MW-1:0] mem_waddr, mem_raddr;
  logic [7:0]  mem_rdata;
  logic [PW-1:0] pos_i;
  logic        rd_pend;
  logic        rd_last;

  assign pos_i = pos[PW-1:0];
  assign stage_raddr = pos_i;
  assign cmd_take  = (state == S_IDLE) && cmd_valid;
  assign back_busy = (state != S_IDLE);
  assign mem_we    = (state == S_COPY) && rd_pend;
  assign mem_waddr = MW'(sel) * MW'(MAX_PAYLOAD) + MW'(pos - 7'd1);
  assign mem_raddr = MW'(sel) * MW'(MAX_PAYLOAD) + MW'(pos_i);

  kmmt_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_pay (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(stage_rdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  // Controller: one slot is examined per cycle in the search.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
      state <= S_IDLE;
      rd_pend <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_group[i]  <= 8'd0;
        slot_node[i]   <= FREE_NODE;
        slot_length[i] <= 6'd0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur <= cmd;
            scan <= '0;
            key_hit <= 1'b0;
            free_hit <= 1'b0;
            if (cmd.action == ACT_CLRA) begin
              for (int i = 0; i < SLOTS; i++) begin
                slot_node[i]   <= FREE_NODE;
                slot_length[i] <= 6'd0;
              end
              strobe <= 1'b1;
              status <= ST_OK; found <= 1'b0; entry_length <= 6'd0;
              payload_byte <= 8'd0; result_last <= 1'b1;
            end else if (cmd.action == ACT_SET && cmd.pre_status != ST_OK) begin
              strobe <= 1'b1;
              status <= cmd.pre_status; found <= 1'b0; entry_length <= 6'd0;
              payload_byte <= 8'd0; result_last <= 1'b1;
            end else begin
              strobe <= 1'b0;
              state <= S_SRCH;
            end
          end else begin
            strobe <= 1'b0;
          end
        end
        S_SRCH: begin
          if (scan < (SW+1)'(SLOTS)) begin
            strobe <= 1'b0;
            if (!key_hit && slot_group[scan[SW-1:0]] == cur.group_id
                && slot_node[scan[SW-1:0]] == cur.node_id) begin
              key_hit <= 1'b1;
              key_idx <= scan[SW-1:0];
            end
            if (!free_hit && slot_node[scan[SW-1:0]] == FREE_NODE) begin
              free_hit <= 1'b1;
              free_idx <= scan[SW-1:0];
            end
            scan <= scan + 1'b1;
          end else begin
            entry_length <= 6'd0;
            payload_byte <= 8'd0; result_last <= 1'b1;
            pos <= 7'd0;
            rd_pend <= 1'b0;
            unique case (cur.action)
              ACT_SET: begin
                found <= 1'b0;
                if (key_hit || free_hit) begin
                  sel <= key_hit ? key_idx : free_idx;
                  len <= cur.count;
                  strobe <= 1'b0; status <= ST_OK;
                  state <= S_COPY;
                end else begin
                  strobe <= 1'b1; status <= ST_FULL; state <= S_IDLE;
                end
              end
              ACT_LOOK: begin
                status <= ST_OK;
                if (key_hit && slot_length[key_idx] != 6'd0) begin
                  sel <= key_idx;
                  len <= (slot_length[key_idx] > 6'(MAX_PAYLOAD))
                         ? 7'(MAX_PAYLOAD) : {1'b0, slot_length[key_idx]};
                  strobe <= 1'b0; found <= 1'b0;
                  state <= S_READ;
                end else begin
                  strobe <= 1'b1; found <= key_hit; state <= S_IDLE;
                end
              end
              default: begin
                if (key_hit) begin
                  slot_node[key_idx]   <= FREE_NODE;
                  slot_length[key_idx] <= 6'd0;
                end
                status <= ST_OK;
                strobe <= 1'b1; found <= key_hit; state <= S_IDLE;
              end
            endcase
          end
        end
        S_COPY: begin
          // The registered staging read at pos lands in the next cycle and is written at pos-1.
          rd_pend <= 1'b1;
          if (pos == len) begin
            slot_group[sel]  <= cur.group_id;
            slot_node[sel]   <= cur.node_id;
            slot_length[sel] <= len[5:0];
            strobe <= 1'b1; entry_length <= len[5:0];
            state <= S_IDLE;
          end else begin
            strobe <= 1'b0;
            pos <= pos + 7'd1;
          end
        end
        S_READ: begin
          // Payload read at pos passes the RAM read register, then the payload_byte register.
          rd_pend <= (pos != len);
          rd_last <= (pos == len - 7'd1);
          strobe <= rd_pend;
          if (rd_pend) begin
            found <= 1'b1; entry_length <= len[5:0];
            payload_byte <= mem_rdata; result_last <= rd_last;
            if (rd_last) begin
              state <= S_IDLE;
            end
          end
          if (pos != len) begin
            pos <= pos + 7'd1;
          end
        end
        default: begin
          strobe <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

### design/keyed_message_mailbox_table.sv
// Keyed message mailbox table: items are taken while busy is low. A set item that
// does not end its set is staged and busy stays low. The item that ends a set, and
// every lookup or clear, raises busy for the hand-off and the slot search; a
// committing set then copies its payload, and a lookup of a stored message reads
// it out. Results come one per cycle on strobe, the last one in the cycle in which
// busy falls; the receiver cannot stall. Clear-all and a rejected set raise busy
// for one cycle.
// Depends on kmmt_pkg, kmmt_front and kmmt_back.
module keyed_message_mailbox_table #(
  parameter int SLOTS       = kmmt_pkg::SLOTS_DEF,
  parameter int MAX_PAYLOAD = kmmt_pkg::MAX_PAYLOAD_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] action,
  input  logic [7:0] group_id,
  input  logic [7:0] node_id,
  input  logic [7:0] data_byte,
  input  logic       has_data,
  input  logic       byte_last,
  output logic       strobe,
  output logic [1:0] status,
  output logic       found,
  output logic [5:0] entry_length,
  output logic [7:0] payload_byte,
  output logic       result_last
);
  import kmmt_pkg::*;

  localparam int PW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic          cmd_valid, cmd_take, back_busy;
  kmmt_cmd_t     cmd;
  logic [PW-1:0] stage_raddr;
  logic [7:0]    stage_rdata;

  // Front: accept and stage.
  kmmt_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk(clk), .rst(rst), .start(start), .action(action), .group_id(group_id),
    .node_id(node_id), .data_byte(data_byte), .has_data(has_data),
    .byte_last(byte_last), .back_busy(back_busy), .busy(busy),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take),
    .stage_raddr(stage_raddr), .stage_rdata(stage_rdata)
  );

  // Back: table search and payload movement.
  kmmt_back #(.SLOTS(SLOTS), .MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd(cmd),
    .cmd_take(cmd_take), .back_busy(back_busy), .stage_raddr(stage_raddr),
    .stage_rdata(stage_rdata), .strobe(strobe), .status(status), .found(found),
    .entry_length(entry_length), .payload_byte(payload_byte),
    .result_last(result_last)
  );
endmodule

### design/kmmt_check.sv
// Port-level checker for the keyed message mailbox table, bound to the top level.
// Depends on kmmt_pkg.
module kmmt_check (
  input logic       clk,
  input logic       rst,
  input logic       busy,
  input logic       strobe,
  input logic [1:0] status,
  input logic       found,
  input logic [5:0] entry_length,
  input logic [7:0] payload_byte
);
  import kmmt_pkg::*;

  // A failed set reports no length.
  a_fail_len: assert property (@(posedge clk) disable iff (rst)
    strobe && status != ST_OK |-> entry_length == 6'd0 && !found)
    else $error("failed set shows a length");

  // Payload bytes come only with a found entry.
  a_pay_found: assert property (@(posedge clk) disable iff (rst)
    strobe && payload_byte != 8'd0 |-> found && status == ST_OK)
    else $error("payload without found entry");

  // Reset leaves the block idle and silent.
  a_reset: assert property (@(posedge clk) rst |=> !strobe && !busy)
    else $error("activity after reset");

  // A found result never carries a non-ok status.
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    strobe && found |-> status == ST_OK)
    else $error("found with error status");
endmodule

bind keyed_message_mailbox_table kmmt_check u_kmmt_check (
  .clk(clk), .rst(rst), .busy(busy), .strobe(strobe),
  .status(status), .found(found), .entry_length(entry_length),
  .payload_byte(payload_byte)
);
